// ===== hw/rtl/pl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_pkg: shared types for the positional list engine
// Request and response payloads, function codes and status codes.
// ----------------------------------------------------------------------------
package pl_pkg;

  localparam int PosW   = 9;
  localparam int CountW = 9;
  localparam int ValW   = 32;

  typedef enum logic [2:0] {
    FN_APPEND    = 3'd0,
    FN_PREPEND   = 3'd1,
    FN_INSERT    = 3'd2,
    FN_REM_LAST  = 3'd3,
    FN_REM_FIRST = 3'd4,
    FN_REM_AT    = 3'd5,
    FN_READ      = 3'd6
  } pl_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } pl_status_e;

  typedef struct packed {
    logic [2:0]             func;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] value;
  } pl_req_t;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    logic [CountW-1:0]      count;
    logic [1:0]             status;
  } pl_rsp_t;

endpackage

// ===== hw/rtl/positional_list_engine_top.sv =====
`timescale 1ns / 1ps
// Sequence: a read addresses the memory, then registers the data; an insert or removal that
//   moves entries (up to CAPACITY-1) shifts them, then an insert writes the new element; an
//   insert at the end only writes it; removal of the last entry, the unused code and any error
//   go straight to the result. One memory move per cycle, set by the single read/write pair.
// Throughput: one request in flight; the next is taken once the result is registered.
// Reset: asynchronous, active low; the list is empty, memory is not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine_top: ordered list of signed 32-bit values
// Append, prepend, insert, remove and read by position over a compact array.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
  parameter int CAPACITY = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pl_pkg::pl_req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pl_pkg::pl_rsp_t out_rsp_o
);
  import pl_pkg::*;

  // count must hold CAPACITY itself; addresses span CAPACITY entries
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int AddrW = $clog2(CAPACITY);

  logic                   seq_busy, seq_done, seq_take;
  pl_rsp_t                seq_rsp;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr, mem_raddr;
  logic signed [ValW-1:0] mem_wdata, mem_rdata;

  logic    out_valid_q;
  pl_rsp_t out_q;

  // Hold off new requests while the sequencer works on one.
  assign in_stall_o = seq_busy;

  pl_seq #(
    .Capacity (CAPACITY),
    .CntW     (CntW),
    .AddrW    (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_req_i),
    .busy_o      (seq_busy),
    .done_o      (seq_done),
    .rsp_o       (seq_rsp),
    .take_i      (seq_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pl_store #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Advance a finished result into the output register when it is empty or
  // being drained this cycle; otherwise hold the sequencer in its done state.
  assign seq_take = seq_done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_take) begin
      out_q <= seq_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  // a result is only finished while no new request can enter
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> in_stall_o)
    else $error("sequencer done while accepting requests");

  // a failed operation never returns data
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status != ST_OK)) |-> (out_rsp_o.read_value == '0))
    else $error("error response carries read data");

  // full and empty codes agree with the reported count
  a_full_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == ST_FULL)) |-> (out_rsp_o.count == CountW'(CAPACITY)))
    else $error("full status with count below capacity");

  a_empty_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == ST_EMPTY)) |-> (out_rsp_o.count == '0))
    else $error("empty status with nonzero count");
`endif

endmodule

// ===== hw/rtl/pl_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_store: element memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pl_store #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic signed [pl_pkg::ValW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic signed [pl_pkg::ValW-1:0] rdata_o
);
  import pl_pkg::*;

  logic signed [ValW-1:0] mem_q [Depth];
  logic signed [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pl_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_seq: list sequencer
// Decodes a request, then walks the memory one entry per cycle through a
// shared cursor incrementer/decrementer to open or close a gap.
// ----------------------------------------------------------------------------
module pl_seq #(
  parameter int Capacity = 256,
  parameter int CntW     = 9,
  parameter int AddrW    = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  pl_pkg::pl_req_t                req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output pl_pkg::pl_rsp_t                rsp_o,
  input  logic                           take_i,
  output logic                           mem_we_o,
  output logic [AddrW-1:0]               mem_waddr_o,
  output logic signed [pl_pkg::ValW-1:0] mem_wdata_o,
  output logic [AddrW-1:0]               mem_raddr_o,
  input  logic signed [pl_pkg::ValW-1:0] mem_rdata_i
);
  import pl_pkg::*;

  localparam int XW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_RWAIT, S_SHIFT, S_FILL, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    K_DONE, K_READ, K_INS, K_REM
  } kind_e;

  state_e                 state_q;
  logic [CntW-1:0]        count_q;
  logic [AddrW-1:0]       cur_q, stop_q, at_q, wb_addr_q;
  logic                   wb_q, rd_act_q, ins_q;
  logic signed [ValW-1:0] val_q, rv_q;
  logic [1:0]             st_q;

  logic [XW-1:0]    pos_x, cnt_x;
  logic             full, empty;
  logic [AddrW-1:0] last_idx, pos_idx;
  logic [1:0]       dec_st;
  kind_e            dec_kind;
  logic [AddrW-1:0] dec_at;
  logic [AddrW-1:0] cur_inc, cur_dec, cur_next, wb_next;

  assign pos_x    = XW'(req_i.position);
  assign cnt_x    = XW'(count_q);
  assign full     = (count_q == CntW'(Capacity));
  assign empty    = (count_q == '0);
  assign last_idx = AddrW'(count_q - 1'b1);
  assign pos_idx  = AddrW'(req_i.position);

  // shared cursor unit: one incrementer, one decrementer
  assign cur_inc  = cur_q + 1'b1;
  assign cur_dec  = cur_q - 1'b1;
  assign cur_next = ins_q ? cur_dec : cur_inc;
  assign wb_next  = ins_q ? cur_inc : cur_dec;

  always_comb begin
    dec_st   = ST_OK;
    dec_kind = K_DONE;
    dec_at   = '0;
    case (req_i.func)
      FN_APPEND: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind = K_INS;
          dec_at   = AddrW'(count_q);
        end
      end
      FN_PREPEND: begin
        if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind = K_INS;
        end
      end
      FN_INSERT: begin
        if (pos_x > cnt_x) begin
          dec_st = ST_RANGE;
        end else if (full) begin
          dec_st = ST_FULL;
        end else begin
          dec_kind = K_INS;
          dec_at   = pos_idx;
        end
      end
      FN_REM_LAST: begin
        if (empty) begin
          dec_st = ST_EMPTY;
        end else begin
          dec_kind = K_REM;
          dec_at   = last_idx;
        end
      end
      FN_REM_FIRST: begin
        if (empty) begin
          dec_st = ST_EMPTY;
        end else begin
          dec_kind = K_REM;
        end
      end
      FN_REM_AT: begin
        if (empty) begin
          dec_st = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          dec_st = ST_RANGE;
        end else begin
          dec_kind = K_REM;
          dec_at   = pos_idx;
        end
      end
      FN_READ: begin
        if (pos_x >= cnt_x) begin
          dec_st = ST_RANGE;
        end else begin
          dec_kind = K_READ;
          dec_at   = pos_idx;
        end
      end
      default: begin
        dec_kind = K_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cur_q     <= '0;
      stop_q    <= '0;
      at_q      <= '0;
      wb_addr_q <= '0;
      wb_q      <= 1'b0;
      rd_act_q  <= 1'b0;
      ins_q     <= 1'b0;
      val_q     <= '0;
      rv_q      <= '0;
      st_q      <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            rv_q  <= '0;
            st_q  <= dec_st;
            at_q  <= dec_at;
            val_q <= req_i.value;
            ins_q <= (dec_kind == K_INS);
            wb_q  <= 1'b0;
            case (dec_kind)
              K_READ: state_q <= S_READ;
              K_INS: begin
                if (CntW'(dec_at) == count_q) begin
                  state_q <= S_FILL;
                end else begin
                  cur_q    <= last_idx;
                  stop_q   <= dec_at;
                  rd_act_q <= 1'b1;
                  state_q  <= S_SHIFT;
                end
              end
              K_REM: begin
                if (dec_at == last_idx) begin
                  count_q <= count_q - 1'b1;
                  state_q <= S_DONE;
                end else begin
                  cur_q    <= dec_at + 1'b1;
                  stop_q   <= last_idx;
                  rd_act_q <= 1'b1;
                  state_q  <= S_SHIFT;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          state_q <= S_RWAIT;
        end
        S_RWAIT: begin
          rv_q    <= mem_rdata_i;
          state_q <= S_DONE;
        end
        S_SHIFT: begin
          wb_q <= rd_act_q;
          if (rd_act_q) begin
            wb_addr_q <= wb_next;
            if (cur_q == stop_q) begin
              rd_act_q <= 1'b0;
            end else begin
              cur_q <= cur_next;
            end
          end else if (!wb_q) begin
            if (ins_q) begin
              state_q <= S_FILL;
            end else begin
              count_q <= count_q - 1'b1;
              state_q <= S_DONE;
            end
          end
        end
        S_FILL: begin
          count_q <= count_q + 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  assign rsp_o.read_value = rv_q;
  assign rsp_o.count      = CountW'(count_q);
  assign rsp_o.status     = st_q;

  // write back the shifted entry, or the new element at the end of an insert
  assign mem_we_o    = ((state_q == S_SHIFT) && wb_q) || (state_q == S_FILL);
  assign mem_waddr_o = (state_q == S_FILL) ? at_q : wb_addr_q;
  assign mem_wdata_o = (state_q == S_FILL) ? val_q : mem_rdata_i;
  assign mem_raddr_o = (state_q == S_READ) ? at_q : cur_q;

endmodule

// ===== tb/pl_list_mirror_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl_list_mirror_pkg: shadow copy of the positional list for checking
// Tracks the ordered element array and count, predicts one response per
// accepted request and compares responses against the oldest prediction.
// ----------------------------------------------------------------------------
package pl_list_mirror_pkg;

  import pl_pkg::*;

  localparam int          MirrorDepth = 256;
  localparam logic [2:0]  FnUnused    = 3'd7;
  localparam int unsigned MaxReports  = 200;

  class list_mirror;

    logic signed [ValW-1:0] elems [MirrorDepth];
    int unsigned            n_elems;
    pl_rsp_t                pending_rsp [$];
    int unsigned            mismatches;

    function new();
      n_elems    = 0;
      mismatches = 0;
      foreach (elems[i]) elems[i] = '0;
    endfunction

    // Shift the tail up by one and drop the new value into the hole.
    function void open_slot(int unsigned at, logic signed [ValW-1:0] v);
      for (int unsigned i = n_elems; i > at; i--) elems[i] = elems[i-1];
      elems[at] = v;
      n_elems++;
    endfunction

    function void close_slot(int unsigned at);
      for (int unsigned i = at; i + 1 < n_elems; i++) elems[i] = elems[i+1];
      n_elems--;
    endfunction

    function void note_request(pl_req_t req);
      pl_rsp_t     rsp;
      int unsigned pos;
      rsp.read_value = '0;
      rsp.status     = ST_OK;
      pos            = req.position;
      case (req.func)
        FN_APPEND: begin
          if (n_elems >= MirrorDepth) rsp.status = ST_FULL;
          else open_slot(n_elems, req.value);
        end
        FN_PREPEND: begin
          if (n_elems >= MirrorDepth) rsp.status = ST_FULL;
          else open_slot(0, req.value);
        end
        FN_INSERT: begin
          // range is judged before fullness
          if (pos > n_elems) rsp.status = ST_RANGE;
          else if (n_elems >= MirrorDepth) rsp.status = ST_FULL;
          else open_slot(pos, req.value);
        end
        FN_REM_LAST: begin
          if (n_elems == 0) rsp.status = ST_EMPTY;
          else close_slot(n_elems - 1);
        end
        FN_REM_FIRST: begin
          if (n_elems == 0) rsp.status = ST_EMPTY;
          else close_slot(0);
        end
        FN_REM_AT: begin
          if (n_elems == 0) rsp.status = ST_EMPTY;
          else if (pos >= n_elems) rsp.status = ST_RANGE;
          else close_slot(pos);
        end
        FN_READ: begin
          if (pos >= n_elems) rsp.status = ST_RANGE;
          else rsp.read_value = elems[pos];
        end
        default: ;
      endcase
      rsp.count = CountW'(n_elems);
      pending_rsp.push_back(rsp);
    endfunction

    function void flag(string field, logic [ValW-1:0] exp_v, logic [ValW-1:0] act_v);
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    endfunction

    function void check_response(pl_rsp_t got);
      pl_rsp_t want;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected response, expected none, actual %h", $time, got);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.read_value !== want.read_value) flag("read_value", want.read_value, got.read_value);
      if (got.count !== want.count) flag("count", ValW'(want.count), ValW'(got.count));
      if (got.status !== want.status) flag("status", ValW'(want.status), ValW'(got.status));
    endfunction

  endclass

endpackage

// ===== tb/tb_positional_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top: self-checking bench for the list engine
// Drives directed corner requests, then long runs of grow and shrink phases
// with random positions and values under varying idle and stall patterns.
// Every response is compared against a shadow copy of the list.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;

  import pl_pkg::*;
  import pl_list_mirror_pkg::*;

  localparam int Capacity     = MirrorDepth;
  localparam int ChunkItems   = 125;
  localparam int ChunkCount   = 14;
  localparam int HoldoffLen   = 400;
  localparam int DrainCycles  = Capacity + 32;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  pl_req_t in_req_i    = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  pl_rsp_t out_rsp_o;

  list_mirror mirror;

  // Idle percentages for the current phase, set by the main sequence.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;

  // Long receiver hold-off: the main sequence bumps the request counter,
  // the receiver process owns the countdown.
  int unsigned holdoff_requests = 0;
  int unsigned holdoff_taken    = 0;
  int unsigned holdoff_left     = 0;

  positional_list_engine_top #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: check each accepted response, then pick the next stall value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_response(out_rsp_o);
    end
    if (holdoff_requests != holdoff_taken) begin
      holdoff_taken = holdoff_requests;
      holdoff_left  = HoldoffLen;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  function automatic pl_req_t make_req(logic [2:0] fn, logic [PosW-1:0] pos,
                                       logic signed [ValW-1:0] val);
    pl_req_t r;
    r.func     = fn;
    r.position = pos;
    r.value    = val;
    return r;
  endfunction

  // Bias values toward the signed extremes now and then.
  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions, some just past the end, a few anywhere.
  function automatic logic [PosW-1:0] pick_position(int unsigned cnt);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return PosW'($urandom_range(cnt, 0));
    if (roll < 95) return PosW'(cnt + $urandom_range(2, 0));
    return PosW'($urandom_range(511, 0));
  endfunction

  // Weight the operation mix toward growth or shrinkage.
  function automatic pl_req_t make_random_req(bit growing, int unsigned cnt);
    pl_req_t     r;
    int unsigned roll;
    r.value    = pick_value();
    r.position = pick_position(cnt);
    roll       = $urandom_range(99);
    if (roll < 3) r.func = FnUnused;
    else if (growing) begin
      if (roll < 33)      r.func = FN_APPEND;
      else if (roll < 53) r.func = FN_PREPEND;
      else if (roll < 78) r.func = FN_INSERT;
      else if (roll < 83) r.func = FN_REM_LAST;
      else if (roll < 88) r.func = FN_REM_FIRST;
      else if (roll < 93) r.func = FN_REM_AT;
      else                r.func = FN_READ;
    end else begin
      if (roll < 33)      r.func = FN_REM_LAST;
      else if (roll < 53) r.func = FN_REM_FIRST;
      else if (roll < 78) r.func = FN_REM_AT;
      else if (roll < 83) r.func = FN_APPEND;
      else if (roll < 88) r.func = FN_PREPEND;
      else if (roll < 93) r.func = FN_INSERT;
      else                r.func = FN_READ;
    end
    return r;
  endfunction

  // Offer one request after a random idle gap and hold it until taken.
  // Valid stays high across back-to-back requests.
  task automatic offer_request(input pl_req_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(req);
  endtask

  task automatic set_phase(input int unsigned phase);
    case (phase)
      1:       begin tx_idle_pct = 72; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 72; end
      3:       begin tx_idle_pct = 36; rx_stall_pct = 36; end
      default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  initial begin
    pl_req_t directed [$];
    bit      growing;
    mirror = new();

    // Hold reset, then release on a clock edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-list errors, the unused code, one-element removal, extremes.
    directed.push_back(make_req(FN_REM_LAST,  9'd0,   32'sd5));
    directed.push_back(make_req(FN_REM_FIRST, 9'd0,   32'sd5));
    directed.push_back(make_req(FN_REM_AT,    9'd0,   32'sd5));
    directed.push_back(make_req(FN_READ,      9'd0,   32'sd5));
    directed.push_back(make_req(FN_INSERT,    9'd1,   32'sd5));
    directed.push_back(make_req(FnUnused,     9'd511, '1));
    directed.push_back(make_req(FN_APPEND,    9'd0,   32'sh7FFF_FFFF));
    directed.push_back(make_req(FN_REM_LAST,  9'd0,   '0));
    directed.push_back(make_req(FN_PREPEND,   9'd0,   32'sh8000_0000));
    directed.push_back(make_req(FN_APPEND,    9'd0,   '1));
    directed.push_back(make_req(FN_INSERT,    9'd1,   '0));
    directed.push_back(make_req(FN_INSERT,    9'd3,   32'sd12345));
    directed.push_back(make_req(FN_INSERT,    9'd5,   32'sd7));
    directed.push_back(make_req(FN_READ,      9'd0,   '0));
    directed.push_back(make_req(FN_READ,      9'd3,   '0));
    directed.push_back(make_req(FN_READ,      9'd4,   '0));
    directed.push_back(make_req(FN_READ,      9'd511, '0));
    directed.push_back(make_req(FN_REM_AT,    9'd1,   '0));
    directed.push_back(make_req(FN_REM_AT,    9'd3,   '0));
    directed.push_back(make_req(FN_REM_AT,    9'd256, '0));
    directed.push_back(make_req(FN_REM_FIRST, 9'd0,   '0));
    directed.push_back(make_req(FN_INSERT,    9'd0,   32'sh5A5A_A5A5));
    directed.push_back(make_req(FnUnused,     9'd0,   '0));
    foreach (directed[i]) offer_request(directed[i]);

    // Random part: chunks cycle through the idle patterns. The list walks
    // up to full and back down to empty, lingering at both ends.
    growing = 1'b1;
    for (int c = 0; c < ChunkCount; c++) begin
      set_phase(c % 5);
      // Back up the output for a long stretch while requests keep coming.
      if (c == 4 || c == 9) holdoff_requests++;
      for (int k = 0; k < ChunkItems; k++) begin
        offer_request(make_random_req(growing, mirror.n_elems));
        if (mirror.n_elems >= Capacity && $urandom_range(7) == 0) growing = 1'b0;
        else if (mirror.n_elems == 0 && $urandom_range(3) == 0) growing = 1'b1;
        else if ($urandom_range(249) == 0) growing = !growing;
      end
    end

    // Drain: drop valid, stop stalling, wait out the last responses.
    in_valid_i   <= 1'b0;
    set_phase(0);
    while (mirror.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mirror.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("%0t: timeout, %0d responses outstanding", $time, mirror.pending_rsp.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
